### rtl/kalman_angle_bias_filter_assert.svh
// Assertion macros shared by the checker file of the angle and bias filter.
`ifndef KALMAN_ANGLE_BIAS_FILTER_ASSERT_SVH
`define KALMAN_ANGLE_BIAS_FILTER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define KABF_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kalman filter check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define KABF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kalman filter check failed");

`endif

### rtl/kabf_pkg.sv
// Shared constants, types and fixed-point helpers of the angle and bias filter.
package kabf_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int HALF_Q24   = 8388608;
  localparam int ONE_Q24    = 16777216;
  localparam int BIAS_LIMIT = 131072000;
  localparam int DIV_STEPS  = 56;

  // Register indexes of the configuration port.
  localparam logic [2:0] CFG_ANGLE_NOISE = 3'd0;
  localparam logic [2:0] CFG_BIAS_NOISE  = 3'd1;
  localparam logic [2:0] CFG_MEAS_NOISE  = 3'd2;
  localparam logic [2:0] CFG_TIME_STEP   = 3'd3;

  // Reset values of the configuration registers.
  localparam logic [23:0] RST_ANGLE_NOISE = 24'd167772;
  localparam logic [23:0] RST_BIAS_NOISE  = 24'd16777;
  localparam logic [23:0] RST_MEAS_NOISE  = 24'd1677722;
  localparam logic [23:0] RST_TIME_STEP   = 24'd83886;

  localparam logic signed [43:0] COV_MIN   = -44'sd2147483648;
  localparam logic signed [43:0] COV_MAX   = 44'sd2147483647;
  localparam logic signed [43:0] ANGLE_MIN = -44'sd16777216;
  localparam logic signed [43:0] ANGLE_MAX = 44'sd16777215;
  localparam logic signed [43:0] BIAS_MIN  = -44'sd131072000;
  localparam logic signed [43:0] BIAS_MAX  = 44'sd131072000;

  // Status of the divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Q8.24 product rescale, rounding half up.
  function automatic logic signed [41:0] rescale(input logic signed [65:0] p);
    logic signed [65:0] r;
    r = p + 66'(HALF_Q24);
    return 42'(r >>> FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    logic signed [43:0] c;
    c = v;
    if (v < COV_MIN) c = COV_MIN;
    if (v > COV_MAX) c = COV_MAX;
    return 32'(c);
  endfunction

  function automatic logic signed [24:0] sat_angle(input logic signed [43:0] v);
    logic signed [43:0] c;
    c = v;
    if (v < ANGLE_MIN) c = ANGLE_MIN;
    if (v > ANGLE_MAX) c = ANGLE_MAX;
    return 25'(c);
  endfunction

  function automatic logic signed [27:0] sat_bias(input logic signed [43:0] v);
    logic signed [43:0] c;
    c = v;
    if (v < BIAS_MIN) c = BIAS_MIN;
    if (v > BIAS_MAX) c = BIAS_MAX;
    return 28'(c);
  endfunction

endpackage

### rtl/kalman_angle_bias_filter.sv
// Top level of the single-axis angle and gyro bias Kalman filter.
// Each accepted sample (gyro rate Q4.24 and accelerometer angle Q1.24) yields one result with
// the filtered angle and the gyro bias. The block works on one sample at a time and holds
// in_stall_o high meanwhile: most of the work lies in two 56-step divisions for the gains
// on the one restoring divider; the other steps run through one shared 34x32 multiplier,
// one product per cycle. The result waits in an output register, and the next sample is
// taken once the result has been loaded there.
module kalman_angle_bias_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [27:0] gyro_rate_i,
  input  logic signed [24:0] measured_angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [24:0] angle_estimate_o,
  output logic signed [27:0] bias_estimate_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_M1, S_ANG1, S_T, S_INNER, S_P00, S_S, S_CHK, S_D0, S_D1S, S_D1,
    S_Y, S_A2, S_B2, S_C10, S_C11, S_C00, S_C01, S_OUT
  } state_e;

  state_e             state_q;
  logic [23:0]        apn_q, bpn_q, rn_q, dt_q;
  logic signed [27:0] rate_q;
  logic signed [24:0] meas_q;
  logic signed [24:0] angle_q;
  logic signed [27:0] bias_q;
  logic signed [31:0] p00_q, p01_q, p10_q, p11_q;
  logic signed [31:0] t_q, k0_q, k1_q;
  logic signed [33:0] s_q;
  logic signed [25:0] y_q, y_d;
  logic signed [65:0] prod_q, prod_d;
  logic signed [33:0] mul_a, inner, one_minus_k0;
  logic signed [31:0] mul_b, dt_s;
  logic signed [41:0] rsc;
  logic               out_valid_q;
  logic signed [24:0] out_angle_q;
  logic signed [27:0] out_bias_q;
  logic               div_start;
  logic signed [31:0] div_num, div_quot;
  kabf_pkg::div_stat_t div_stat;

  // Shared gain divider.
  kabf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (s_q[31:0]),
    .stat_o (div_stat),
    .quot_o (div_quot)
  );

  assign div_start = ((state_q == S_CHK) && (s_q > 34'sd0)) || (state_q == S_D1S);
  assign div_num   = (state_q == S_D1S) ? p10_q : p00_q;

  // Operands of the shared multiplier, chosen by the sequencer step.
  always_comb begin
    dt_s         = $signed(32'(dt_q));
    inner        = 34'(t_q) - 34'(p01_q) - 34'(p10_q) + $signed(34'(apn_q));
    one_minus_k0 = 34'(kabf_pkg::ONE_Q24) - 34'(k0_q);
    y_d          = 26'(meas_q) - 26'(angle_q);
    rsc          = kabf_pkg::rescale(prod_q);
    mul_a        = '0;
    mul_b        = '0;
    case (state_q)
      S_M1: begin
        mul_a = 34'(rate_q) - 34'(bias_q);
        mul_b = dt_s;
      end
      S_ANG1: begin
        mul_a = 34'(p11_q);
        mul_b = dt_s;
      end
      S_INNER: begin
        mul_a = inner;
        mul_b = dt_s;
      end
      S_Y: begin
        mul_a = 34'(k0_q);
        mul_b = 32'(y_d);
      end
      S_A2: begin
        mul_a = 34'(k1_q);
        mul_b = 32'(y_q);
      end
      S_B2: begin
        mul_a = 34'(k1_q);
        mul_b = p00_q;
      end
      S_C10: begin
        mul_a = 34'(k1_q);
        mul_b = p01_q;
      end
      S_C11: begin
        mul_a = one_minus_k0;
        mul_b = p00_q;
      end
      S_C00: begin
        mul_a = one_minus_k0;
        mul_b = p01_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // Sequencer, filter state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      apn_q       <= kabf_pkg::RST_ANGLE_NOISE;
      bpn_q       <= kabf_pkg::RST_BIAS_NOISE;
      rn_q        <= kabf_pkg::RST_MEAS_NOISE;
      dt_q        <= kabf_pkg::RST_TIME_STEP;
      rate_q      <= '0;
      meas_q      <= '0;
      angle_q     <= '0;
      bias_q      <= '0;
      p00_q       <= 32'(kabf_pkg::ONE_Q24);
      p01_q       <= '0;
      p10_q       <= '0;
      p11_q       <= 32'(kabf_pkg::ONE_Q24);
      t_q         <= '0;
      k0_q        <= '0;
      k1_q        <= '0;
      s_q         <= '0;
      y_q         <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_angle_q <= '0;
      out_bias_q  <= '0;
    end else begin
      prod_q <= prod_d;
      // A finished transfer frees the output register unless a new result is loaded.
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) out_valid_q <= 1'b0;

      // Configuration writes; unknown indexes are ignored.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kabf_pkg::CFG_ANGLE_NOISE: apn_q <= cfg_wdata_i;
          kabf_pkg::CFG_BIAS_NOISE:  bpn_q <= cfg_wdata_i;
          kabf_pkg::CFG_MEAS_NOISE:  rn_q  <= cfg_wdata_i;
          kabf_pkg::CFG_TIME_STEP:   dt_q  <= cfg_wdata_i;
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            rate_q  <= gyro_rate_i;
            meas_q  <= measured_angle_i;
            state_q <= S_M1;
          end
        end
        S_M1: state_q <= S_ANG1;
        S_ANG1: begin
          angle_q <= kabf_pkg::sat_angle(44'(angle_q) + 44'(rsc));
          state_q <= S_T;
        end
        S_T: begin
          t_q     <= 32'(rsc);
          state_q <= S_INNER;
        end
        S_INNER: begin
          p01_q   <= kabf_pkg::sat32(44'(p01_q) - 44'(t_q));
          p10_q   <= kabf_pkg::sat32(44'(p10_q) - 44'(t_q));
          p11_q   <= kabf_pkg::sat32(44'(p11_q) + $signed(44'(bpn_q)));
          state_q <= S_P00;
        end
        S_P00: begin
          p00_q   <= kabf_pkg::sat32(44'(p00_q) + 44'(rsc));
          state_q <= S_S;
        end
        S_S: begin
          s_q     <= 34'(p00_q) + $signed(34'(rn_q));
          state_q <= S_CHK;
        end
        S_CHK: begin
          // A non-positive innovation variance gives zero gains.
          if (s_q > 34'sd0) begin
            state_q <= S_D0;
          end else begin
            k0_q    <= '0;
            k1_q    <= '0;
            state_q <= S_Y;
          end
        end
        S_D0: begin
          if (div_stat.done) begin
            k0_q    <= div_quot;
            state_q <= S_D1S;
          end
        end
        S_D1S: state_q <= S_D1;
        S_D1: begin
          if (div_stat.done) begin
            k1_q    <= div_quot;
            state_q <= S_Y;
          end
        end
        S_Y: begin
          y_q     <= y_d;
          state_q <= S_A2;
        end
        S_A2: begin
          angle_q <= kabf_pkg::sat_angle(44'(angle_q) + 44'(rsc));
          state_q <= S_B2;
        end
        S_B2: begin
          bias_q  <= kabf_pkg::sat_bias(44'(bias_q) + 44'(rsc));
          state_q <= S_C10;
        end
        S_C10: begin
          p10_q   <= kabf_pkg::sat32(44'(p10_q) - 44'(rsc));
          state_q <= S_C11;
        end
        S_C11: begin
          p11_q   <= kabf_pkg::sat32(44'(p11_q) - 44'(rsc));
          state_q <= S_C00;
        end
        S_C00: begin
          p00_q   <= kabf_pkg::sat32(44'(rsc));
          state_q <= S_C01;
        end
        S_C01: begin
          p01_q   <= kabf_pkg::sat32(44'(rsc));
          state_q <= S_OUT;
        end
        S_OUT: begin
          // Load the result once the output register is free.
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_angle_q <= angle_q;
            out_bias_q  <= bias_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign angle_estimate_o = out_angle_q;
  assign bias_estimate_o  = out_bias_q;

endmodule

### rtl/kabf_div.sv
// Restoring divider for the gain: (num * 2^24) / den, one quotient bit per cycle.
module kabf_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [31:0]  num_i,
  input  logic        [31:0]  den_i,
  output kabf_pkg::div_stat_t stat_o,
  output logic signed [31:0]  quot_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;
  logic [31:0] den_q, den_d;
  logic [31:0] rem_q, rem_d;
  logic [55:0] dq_q, dq_d;
  logic [31:0] mag;
  logic [32:0] shifted;
  logic [33:0] trial;
  logic        fit;

  // One trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    mag     = num_i[31] ? (~num_i + 32'd1) : num_i;
    shifted = {rem_q, dq_q[55]};
    trial   = {1'b0, shifted} - {2'b00, den_q};
    fit     = !trial[33];
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    den_d   = den_q;
    rem_d   = rem_q;
    dq_d    = dq_q;
    if (busy_q) begin
      rem_d = fit ? trial[31:0] : shifted[31:0];
      dq_d  = {dq_q[54:0], fit};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(kabf_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = num_i[31];
      den_d  = den_i;
      rem_d  = '0;
      dq_d   = {mag, 24'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      den_q  <= '0;
      rem_q  <= '0;
      dq_q   <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      neg_q  <= neg_d;
      den_q  <= den_d;
      rem_q  <= rem_d;
      dq_q   <= dq_d;
    end
  end

  // Apply the sign and clamp the quotient to the signed 32-bit range.
  always_comb begin
    if (neg_q) begin
      if (dq_q > 56'h80000000) quot_o = 32'sh80000000;
      else quot_o = 32'(56'd0 - dq_q);
    end else begin
      if (dq_q > 56'h7FFFFFFF) quot_o = 32'sh7FFFFFFF;
      else quot_o = dq_q[31:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### rtl/kabf_checker.sv
// Port-level checks of the angle and bias filter, bound to the top level.
`include "kalman_angle_bias_filter_assert.svh"

module kabf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [24:0] angle_estimate_o,
  input logic signed [27:0] bias_estimate_o
);

  logic        in_xfer;
  logic        out_hold;
  logic [52:0] out_data;
  logic        bias_ok;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_hold = out_valid_o && out_stall_i;
  assign out_data = {angle_estimate_o, bias_estimate_o};
  assign bias_ok  = (bias_estimate_o >= -28'sd131072000) &&
                    (bias_estimate_o <= 28'sd131072000);

  // A stalled result stays put.
  `KABF_ASSERT_NEXT(a_out_hold, out_hold, out_valid_o && $stable(out_data))

  // After a transfer the block is busy with that sample.
  `KABF_ASSERT_NEXT(a_busy_after_in, in_xfer, in_stall_o)

  // No result appears right after a sample is taken.
  `KABF_ASSERT_NEXT(a_no_early_out, in_xfer, !$rose(out_valid_o))

  // The bias stays within its saturation limits.
  `KABF_ASSERT(a_bias_range, out_valid_o, bias_ok)

endmodule

bind kalman_angle_bias_filter kabf_checker u_kabf_checker (.*);

### dv/testbench.sv
// Self-checking testbench for the angle and gyro bias Kalman filter.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  WATCHDOG_LIMIT = 6000;
  localparam int  HOLD_CYCLES    = 800;
  localparam int  PHASE_ITEMS    = 130;
  localparam int  NUM_PHASES     = 7;
  localparam longint RATE_SPAN   = 131072000;
  localparam longint MEAS_SPAN   = 11796480;
  localparam longint Q_ANGLE_MIN = -16777216;
  localparam longint Q_ANGLE_MAX = 16777215;
  localparam longint Q_COV_MIN   = -64'sd2147483648;
  localparam longint Q_COV_MAX   = 64'sd2147483647;

  // Filter predictor and the queue of estimates still owed by the block.
  class kalman_scoreboard;
    longint qa, qb, rn, dt;
    longint ang, bia, p00, p01, p10, p11;
    logic signed [24:0] owed_angle[$];
    logic signed [27:0] owed_bias[$];
    int errors, matched;

    function new();
      qa = kabf_pkg::RST_ANGLE_NOISE; qb = kabf_pkg::RST_BIAS_NOISE;
      rn = kabf_pkg::RST_MEAS_NOISE;  dt = kabf_pkg::RST_TIME_STEP;
      ang = 0; bia = 0; p00 = kabf_pkg::ONE_Q24; p01 = 0; p10 = 0;
      p11 = kabf_pkg::ONE_Q24;
      errors = 0; matched = 0;
    endfunction

    function longint rnd(longint v);
      return (v + kabf_pkg::HALF_Q24) >>> kabf_pkg::FRAC_BITS;
    endfunction

    function longint lim(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void set_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        kabf_pkg::CFG_ANGLE_NOISE: qa = val;
        kabf_pkg::CFG_BIAS_NOISE:  qb = val;
        kabf_pkg::CFG_MEAS_NOISE:  rn = val;
        kabf_pkg::CFG_TIME_STEP:   dt = val;
        default: ;
      endcase
    endfunction

    // One predict and correct step for an accepted sample.
    function void note_sample(logic signed [27:0] rate_in, logic signed [24:0] meas_in);
      longint rate, meas, t, s, y, k0, k1, a00, a01, a10, a11, one;
      one = kabf_pkg::ONE_Q24;
      rate = rate_in;
      meas = meas_in;
      ang = lim(ang + rnd((rate - bia) * dt), Q_ANGLE_MIN, Q_ANGLE_MAX);
      t = rnd(dt * p11);
      p00 = lim(p00 + rnd(dt * (t - p01 - p10 + qa)), Q_COV_MIN, Q_COV_MAX);
      p01 = lim(p01 - t, Q_COV_MIN, Q_COV_MAX);
      p10 = lim(p10 - t, Q_COV_MIN, Q_COV_MAX);
      p11 = lim(p11 + qb, Q_COV_MIN, Q_COV_MAX);
      a00 = p00; a01 = p01; a10 = p10; a11 = p11;
      s = a00 + rn;
      k0 = 0;
      k1 = 0;
      // A non-positive innovation variance leaves both gains at zero.
      if (s > 0) begin
        k0 = lim((a00 * one) / s, Q_COV_MIN, Q_COV_MAX);
        k1 = lim((a10 * one) / s, Q_COV_MIN, Q_COV_MAX);
      end
      y = meas - ang;
      ang = lim(ang + rnd(k0 * y), Q_ANGLE_MIN, Q_ANGLE_MAX);
      bia = lim(bia + rnd(k1 * y), -longint'(kabf_pkg::BIAS_LIMIT),
                longint'(kabf_pkg::BIAS_LIMIT));
      p00 = lim(rnd((one - k0) * a00), Q_COV_MIN, Q_COV_MAX);
      p01 = lim(rnd((one - k0) * a01), Q_COV_MIN, Q_COV_MAX);
      p10 = lim(a10 - rnd(k1 * a00), Q_COV_MIN, Q_COV_MAX);
      p11 = lim(a11 - rnd(k1 * a01), Q_COV_MIN, Q_COV_MAX);
      owed_angle.push_back(ang[24:0]);
      owed_bias.push_back(bia[27:0]);
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task check_result(logic signed [24:0] a, logic signed [27:0] b);
      logic signed [24:0] ea;
      logic signed [27:0] eb;
      if (owed_angle.size() == 0) begin
        report("unexpected result, angle", a, 0);
      end else begin
        ea = owed_angle.pop_front();
        eb = owed_bias.pop_front();
        if (a !== ea) report("angle_estimate", a, ea);
        if (b !== eb) report("bias_estimate", b, eb);
        if (a === ea && b === eb) matched++;
      end
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [23:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [27:0] gyro_rate_i = '0;
  logic signed [24:0] measured_angle_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [24:0] angle_estimate_o;
  logic signed [27:0] bias_estimate_o;

  kalman_scoreboard sb = new();
  int sent = 0;
  int received = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;
  bit held = 1'b0;

  kalman_angle_bias_filter uut (.*);

  always #10 clk_i = ~clk_i;

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
        $display("kalman_angle_bias_filter verification failed");
        $finish;
      end
    end
  end

  // Result side: random stall, one long hold-off, a stall-free stretch, check every transfer.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(angle_estimate_o, bias_estimate_o);
        received++;
      end
      @(negedge clk_i);
      if (received == 150 && !held) begin
        held = 1'b1;
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i = 1'b0;
      end else if (received >= 320 && received < 470) begin
        out_stall_i = 1'b0;
      end else begin
        out_stall_i = ($urandom_range(99) < 22);
      end
    end
  end

  task write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Offers one sample and holds it until the block takes it.
  task send_sample(logic signed [27:0] rate, logic signed [24:0] meas);
    if (!no_gaps) begin
      while ($urandom_range(99) < 22) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    gyro_rate_i = rate;
    measured_angle_i = meas;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(rate, meas);
    sent++;
    @(negedge clk_i);
  endtask

  task wait_drained();
    in_valid_i = 1'b0;
    while (sb.owed_angle.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task random_sample();
    logic signed [27:0] r;
    logic signed [24:0] m;
    if ($urandom_range(99) < 15) begin
      r = 28'($urandom);
      m = 25'($urandom);
    end else begin
      r = 28'(longint'($urandom_range(2 * RATE_SPAN)) - RATE_SPAN);
      m = 25'(longint'($urandom_range(2 * MEAS_SPAN)) - MEAS_SPAN);
    end
    send_sample(r, m);
  endtask

  initial begin
    logic [23:0] v;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Field extremes and out-of-range inputs under the reset settings.
    send_sample('0, '0);
    send_sample(28'(RATE_SPAN), 25'(MEAS_SPAN));
    send_sample(28'(-RATE_SPAN), 25'(-MEAS_SPAN));
    send_sample(28'sh7FFFFFF, 25'sh0FFFFFF);
    send_sample(28'sh8000000, 25'sh1000000);
    send_sample(28'sh7FFFFFF, 25'sh1000000);
    send_sample(28'sh8000000, 25'sh0FFFFFF);
    for (int i = 0; i < 6; i++) send_sample(28'sh7FFFFFF, 25'sh0FFFFFF);
    for (int i = 0; i < 6; i++) send_sample(28'sh8000000, 25'sh1000000);
    wait_drained();

    // Writes to unused indexes must be ignored.
    for (int i = kabf_pkg::CFG_TIME_STEP + 1; i < 8; i++) write_reg(i[2:0], 24'($urandom));
    send_sample(28'(RATE_SPAN / 2), 25'(MEAS_SPAN / 3));
    send_sample(28'(-RATE_SPAN / 5), 25'(MEAS_SPAN));
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      for (int idx = kabf_pkg::CFG_ANGLE_NOISE; idx <= kabf_pkg::CFG_TIME_STEP; idx++) begin
        case (ph)
          0: v = 24'hFFFFFF;
          1: v = 24'h000000;
          2: v = (idx == kabf_pkg::CFG_MEAS_NOISE) ? 24'h000000 : 24'hFFFFFF;
          3: v = (idx == kabf_pkg::CFG_TIME_STEP) ? 24'h000001 : 24'hFFFFFF;
          default: v = 24'($urandom);
        endcase
        write_reg(idx[2:0], v);
      end
      no_gaps = (ph == 4);
      for (int i = 0; i < PHASE_ITEMS; i++) random_sample();
      no_gaps = 1'b0;
      wait_drained();
    end

    in_valid_i = 1'b0;
    repeat (300) @(negedge clk_i);
    $display("Sent %0d samples through %0d register settings, including extremes,",
             sent, NUM_PHASES + 1);
    $display("with random gaps, a long output hold-off and %0d matched results.", sb.matched);
    if (sb.errors == 0 && sb.owed_angle.size() == 0) begin
      $display("kalman_angle_bias_filter verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.owed_angle.size());
      $display("kalman_angle_bias_filter verification failed");
    end
    $finish;
  end

endmodule
